[hdl/fdd_pkg.sv]
// Shared types and constants for the IMU fall direction detector.
package fdd_pkg;

    localparam int WINDOW    = 5;
    localparam int ANGLE_W   = 13;
    localparam int DELTA_W   = ANGLE_W + 1;
    localparam int RATE_W    = 16;
    localparam int LIMIT_W   = 3;
    localparam int NUM_DIR   = 4;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam int DIR_FWD   = 0;
    localparam int DIR_BACK  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    typedef enum logic [2:0] {
        REG_FWD_ROLL_CHG  = 3'd0,
        REG_FWD_RATE_X    = 3'd1,
        REG_BACK_ROLL     = 3'd2,
        REG_BACK_ROLL_CHG = 3'd3,
        REG_BACK_RATE_X   = 3'd4,
        REG_SIDE_PITCH    = 3'd5,
        REG_SIDE_RATE_Y   = 3'd6,
        REG_DEBOUNCE      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [13:0] fwd_roll_chg;
        logic signed [15:0] fwd_rate_x;
        logic signed [12:0] back_roll;
        logic signed [13:0] back_roll_chg;
        logic signed [15:0] back_rate_x;
        logic        [12:0] side_pitch_chg;
        logic        [14:0] side_rate_y;
        logic [LIMIT_W-1:0] debounce;
    } cfg_t;

endpackage

[hdl/fdd_ifs.sv]
// Handshake interfaces for the sample and result channels.
interface fdd_sample_if
    import fdd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [RATE_W-1:0]  rate_x;
    logic signed [RATE_W-1:0]  rate_y;

    modport source (output valid, pitch_angle, roll_angle, rate_x, rate_y, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, rate_x, rate_y, output ready);
endinterface

interface fdd_result_if
    import fdd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [NUM_DIR-1:0] fall_mask;

    modport source (output valid, fall_mask, input ready);
    modport sink   (input valid, fall_mask, output ready);
endinterface

[hdl/fdd_regs.sv]
// APB configuration registers of the fall direction detector.
module fdd_regs
    import fdd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fwd_roll_chg   <= -14'sd80;
            cfg_reg.fwd_rate_x     <= -16'sd800;
            cfg_reg.back_roll      <= 13'sd960;
            cfg_reg.back_roll_chg  <= 14'sd128;
            cfg_reg.back_rate_x    <= 16'sd960;
            cfg_reg.side_pitch_chg <= 13'd96;
            cfg_reg.side_rate_y    <= 15'd560;
            cfg_reg.debounce       <= 3'd4;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FWD_ROLL_CHG:  cfg_reg.fwd_roll_chg   <= $signed(pwdata[13:0]);
                REG_FWD_RATE_X:    cfg_reg.fwd_rate_x     <= $signed(pwdata[15:0]);
                REG_BACK_ROLL:     cfg_reg.back_roll      <= $signed(pwdata[12:0]);
                REG_BACK_ROLL_CHG: cfg_reg.back_roll_chg  <= $signed(pwdata[13:0]);
                REG_BACK_RATE_X:   cfg_reg.back_rate_x    <= $signed(pwdata[15:0]);
                REG_SIDE_PITCH:    cfg_reg.side_pitch_chg <= pwdata[12:0];
                REG_SIDE_RATE_Y:   cfg_reg.side_rate_y    <= pwdata[14:0];
                REG_DEBOUNCE:      cfg_reg.debounce       <= pwdata[LIMIT_W-1:0];
            endcase
        end
    end

    // Signed registers read back sign-extended to the bus width.
    always_comb
    begin
        unique case (idx)
            REG_FWD_ROLL_CHG:  prdata = {{18{cfg_reg.fwd_roll_chg[13]}}, cfg_reg.fwd_roll_chg};
            REG_FWD_RATE_X:    prdata = {{16{cfg_reg.fwd_rate_x[15]}}, cfg_reg.fwd_rate_x};
            REG_BACK_ROLL:     prdata = {{19{cfg_reg.back_roll[12]}}, cfg_reg.back_roll};
            REG_BACK_ROLL_CHG: prdata = {{18{cfg_reg.back_roll_chg[13]}},
                                         cfg_reg.back_roll_chg};
            REG_BACK_RATE_X:   prdata = {{16{cfg_reg.back_rate_x[15]}}, cfg_reg.back_rate_x};
            REG_SIDE_PITCH:    prdata = {19'd0, cfg_reg.side_pitch_chg};
            REG_SIDE_RATE_Y:   prdata = {17'd0, cfg_reg.side_rate_y};
            REG_DEBOUNCE:      prdata = {{(PDATA_W-LIMIT_W){1'b0}}, cfg_reg.debounce};
        endcase
    end

endmodule

[hdl/fdd_window.sv]
// Pitch and roll delay line that forms the change over the window.
module fdd_window
    import fdd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic signed [ANGLE_W-1:0] pitch,
    input  logic signed [ANGLE_W-1:0] roll,
    output logic signed [DELTA_W-1:0] d_pitch,
    output logic signed [DELTA_W-1:0] d_roll
);

    logic signed [ANGLE_W-1:0] pitch_hist_reg [WINDOW];
    logic signed [ANGLE_W-1:0] roll_hist_reg  [WINDOW];
    logic signed [ANGLE_W-1:0] pitch_old;
    logic signed [ANGLE_W-1:0] roll_old;

    // The last tap holds the sample taken a full window earlier.
    assign pitch_old = pitch_hist_reg[WINDOW-1];
    assign roll_old  = roll_hist_reg[WINDOW-1];
    assign d_pitch   = $signed({pitch[ANGLE_W-1], pitch}) -
                       $signed({pitch_old[ANGLE_W-1], pitch_old});
    assign d_roll    = $signed({roll[ANGLE_W-1], roll}) -
                       $signed({roll_old[ANGLE_W-1], roll_old});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                pitch_hist_reg[i] <= '0;
                roll_hist_reg[i]  <= '0;
            end
        end
        else if (step)
        begin
            pitch_hist_reg[0] <= pitch;
            roll_hist_reg[0]  <= roll;
            for (int i = 1; i < WINDOW; i++)
            begin
                pitch_hist_reg[i] <= pitch_hist_reg[i-1];
                roll_hist_reg[i]  <= roll_hist_reg[i-1];
            end
        end
    end

endmodule

[hdl/fdd_detect.sv]
// Direction rules and debounce counters that form the fall mask.
module fdd_detect
    import fdd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  cfg_t                      cfg,
    input  logic signed [ANGLE_W-1:0] pitch,
    input  logic signed [ANGLE_W-1:0] roll,
    input  logic signed [RATE_W-1:0]  rate_x,
    input  logic signed [RATE_W-1:0]  rate_y,
    input  logic signed [DELTA_W-1:0] d_pitch,
    input  logic signed [DELTA_W-1:0] d_roll,
    output logic [NUM_DIR-1:0]        fall_mask
);

    logic [LIMIT_W-1:0] cnt_reg  [NUM_DIR];
    logic [LIMIT_W-1:0] cnt_next [NUM_DIR];
    logic [LIMIT_W-1:0] cnt_upd  [NUM_DIR];
    logic [NUM_DIR-1:0] hit;

    logic signed [DELTA_W:0]  d_pitch_x;
    logic signed [DELTA_W:0]  pitch_lim_pos;
    logic signed [DELTA_W:0]  pitch_lim_neg;
    logic signed [RATE_W:0]   rate_y_x;
    logic signed [RATE_W:0]   rate_lim_pos;
    logic signed [RATE_W:0]   rate_lim_neg;

    assign d_pitch_x     = $signed({d_pitch[DELTA_W-1], d_pitch});
    assign pitch_lim_pos = $signed({2'b00, cfg.side_pitch_chg});
    assign pitch_lim_neg = -pitch_lim_pos;
    assign rate_y_x      = $signed({rate_y[RATE_W-1], rate_y});
    assign rate_lim_pos  = $signed({2'b00, cfg.side_rate_y});
    assign rate_lim_neg  = -rate_lim_pos;

    always_comb
    begin
        hit[DIR_FWD]   = (d_roll <= cfg.fwd_roll_chg) && (rate_x <= cfg.fwd_rate_x);
        hit[DIR_BACK]  = (roll > cfg.back_roll) && (d_roll > cfg.back_roll_chg) &&
                         (rate_x > cfg.back_rate_x);
        hit[DIR_LEFT]  = (d_pitch_x < pitch_lim_neg) && pitch[ANGLE_W-1] &&
                         (rate_y_x < rate_lim_neg);
        hit[DIR_RIGHT] = (d_pitch_x > pitch_lim_pos) && (pitch > 0) &&
                         (rate_y_x > rate_lim_pos);
    end

    // A counter climbs toward the limit on a hit and decays otherwise; reaching
    // the limit flags the direction and restarts the count from zero.
    always_comb
    begin
        for (int k = 0; k < NUM_DIR; k++)
        begin
            if (hit[k])
                cnt_upd[k] = (cnt_reg[k] < cfg.debounce) ? cnt_reg[k] + 1'b1 : cnt_reg[k];
            else
                cnt_upd[k] = (cnt_reg[k] != '0) ? cnt_reg[k] - 1'b1 : cnt_reg[k];
            fall_mask[k] = (cnt_upd[k] >= cfg.debounce);
            cnt_next[k]  = fall_mask[k] ? '0 : cnt_upd[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_DIR; k++)
                cnt_reg[k] <= '0;
        end
        else if (step)
        begin
            for (int k = 0; k < NUM_DIR; k++)
                cnt_reg[k] <= cnt_next[k];
        end
    end

endmodule

[hdl/imu_fall_direction_detector.sv]
// Top level of the IMU fall direction detector.
// Path: a sample item accepted into the input register yields its result item
// in the result register (input register, then result register).
// Throughput: one item per cycle while results are taken; an empty input register lets a new
// item in while a finished result still waits to be taken.
// Reset: rst_n clears the delay line, the debounce counters and all valid
// flags, and loads the configuration registers with their defaults.
module imu_fall_direction_detector
    import fdd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    fdd_sample_if.sink         sample,
    fdd_result_if.source       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Input register: holds one accepted sample until the result register
    // can take its outcome.
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic signed [ANGLE_W-1:0] pitch_reg;
    logic signed [ANGLE_W-1:0] roll_reg;
    logic signed [RATE_W-1:0]  rate_x_reg;
    logic signed [RATE_W-1:0]  rate_y_reg;

    // Result register.
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [NUM_DIR-1:0]        mask_reg;

    logic                      accept;
    logic                      advance;
    cfg_t                      cfg;
    logic signed [DELTA_W-1:0] d_pitch;
    logic signed [DELTA_W-1:0] d_roll;
    logic [NUM_DIR-1:0]        fall_mask;

    // The held sample is processed, and the detector state stepped, in the
    // cycle in which its result moves into a free or draining result register.
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign accept       = sample.valid && sample.ready;

    assign result.valid     = out_valid_reg;
    assign result.fall_mask = mask_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pitch_reg  <= sample.pitch_angle;
            roll_reg   <= sample.roll_angle;
            rate_x_reg <= sample.rate_x;
            rate_y_reg <= sample.rate_y;
        end
        if (advance)
            mask_reg <= fall_mask;
    end

    fdd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Change of pitch and roll against the sample one window earlier.
    fdd_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .pitch   (pitch_reg),
        .roll    (roll_reg),
        .d_pitch (d_pitch),
        .d_roll  (d_roll)
    );

    // Direction rules and debounce counters.
    fdd_detect u_detect (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .cfg       (cfg),
        .pitch     (pitch_reg),
        .roll      (roll_reg),
        .rate_x    (rate_x_reg),
        .rate_y    (rate_y_reg),
        .d_pitch   (d_pitch),
        .d_roll    (d_roll),
        .fall_mask (fall_mask)
    );

endmodule
